// File: rtl/bscf_pkg.sv
// Shared types and constants for the byte-stuffed CRC framer.
`timescale 1ns / 1ps
`default_nettype none

package bscf_pkg;

  // Configuration register indexes
  localparam logic REG_MAX_LEN = 1'b0;
  localparam logic REG_CRC_EN  = 1'b1;

  localparam int CFG_DW = 13;

  // Job queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  // One classified input byte, as handed from the front end to the back end
  typedef struct packed {
    logic        ovf;      // length exceeded: emit the single overflow beat
    logic        lead;     // leading separator still owed
    logic [7:0]  data;     // payload byte
    logic        last;     // byte closes the message
    logic        crc_en;   // append CRC before the closing separator
    logic [15:0] crc;      // CRC including this byte
  } job_t;

  // Queue status seen by both ends
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/bscf_front.sv
// Front end: configuration registers, length check, CRC update and job issue.
`timescale 1ns / 1ps
`default_nettype none

module bscf_front #(
  parameter int MAX_MESSAGE_LIMIT = 4096
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic                       cfg_index,
  input  wire logic [bscf_pkg::CFG_DW-1:0] cfg_data,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [7:0]                 s_tdata,
  input  wire logic                       s_tlast,
  input  wire bscf_pkg::q_stat_t          q_stat,
  output logic                            push,
  output bscf_pkg::job_t                  push_job
);

  localparam int CW   = $clog2(MAX_MESSAGE_LIMIT + 1);
  localparam int CMPW = (CW > bscf_pkg::CFG_DW) ? CW : bscf_pkg::CFG_DW;

  logic [bscf_pkg::CFG_DW-1:0] max_len;
  logic                        crc_en;
  logic                        leading;
  logic                        discarding;
  logic [CW-1:0]               byte_count;
  logic [15:0]                 crc_value;

  logic [CMPW-1:0] len_ext;
  logic [CMPW-1:0] limit;
  logic            at_limit;
  logic            accept;
  logic [15:0]     crc_next;

  // CRC-16, poly 0x1021, MSB first, one byte
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ 16'h1021) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  // Saturate the configured length to the build limit
  always_comb begin
    len_ext  = CMPW'(max_len);
    limit    = (len_ext > CMPW'(MAX_MESSAGE_LIMIT)) ? CMPW'(MAX_MESSAGE_LIMIT) : len_ext;
    at_limit = CMPW'(byte_count) >= limit;
    crc_next = crc_add(crc_value, s_tdata);
  end

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  // Build the job for this beat
  always_comb begin
    push_job        = '0;
    push_job.ovf    = at_limit;
    push_job.lead   = leading;
    push_job.data   = s_tdata;
    push_job.last   = s_tlast;
    push_job.crc_en = crc_en;
    push_job.crc    = crc_next;
    push            = accept && !discarding;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= bscf_pkg::CFG_DW'(128);
      crc_en  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bscf_pkg::REG_MAX_LEN: max_len <= cfg_data;
        bscf_pkg::REG_CRC_EN:  crc_en  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Message state
  always_ff @(posedge clk) begin
    if (rst) begin
      leading    <= 1'b1;
      discarding <= 1'b0;
      byte_count <= '0;
      crc_value  <= '0;
    end else if (accept) begin
      priority if (discarding) begin
        if (s_tlast) begin
          discarding <= 1'b0;
          byte_count <= '0;
          crc_value  <= '0;
        end
      end else if (at_limit) begin
        discarding <= !s_tlast;
        byte_count <= '0;
        crc_value  <= '0;
      end else begin
        leading <= 1'b0;
        if (s_tlast) begin
          byte_count <= '0;
          crc_value  <= '0;
        end else begin
          byte_count <= byte_count + CW'(1);
          crc_value  <= crc_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/bscf_queue.sv
// Short job queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module bscf_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bscf_pkg::job_t push_job,
  input  wire logic           pop,
  output bscf_pkg::job_t      head,
  output bscf_pkg::q_stat_t   stat
);

  bscf_pkg::job_t                  slots [bscf_pkg::QUEUE_DEPTH];
  logic [bscf_pkg::QUEUE_AW-1:0]   wr_ptr;
  logic [bscf_pkg::QUEUE_AW-1:0]   rd_ptr;
  logic [bscf_pkg::QUEUE_CW-1:0]   fill;

  assign head       = slots[rd_ptr];
  assign stat.full  = fill == bscf_pkg::QUEUE_CW'(bscf_pkg::QUEUE_DEPTH);
  assign stat.empty = fill == '0;

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + bscf_pkg::QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + bscf_pkg::QUEUE_AW'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + bscf_pkg::QUEUE_CW'(1);
        2'b01:   fill <= fill - bscf_pkg::QUEUE_CW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/bscf_back.sv
// Back end: expands each job into stuffed line beats through an output register.
`timescale 1ns / 1ps
`default_nettype none

module bscf_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire bscf_pkg::job_t    head,
  input  wire bscf_pkg::q_stat_t q_stat,
  output logic                   pop,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [7:0]             m_tdata,   // line_byte
  output logic                   m_tlast,
  output logic [1:0]             m_tuser    // [0] frame_done, [1] overflow
);

  localparam logic [7:0] ESC_BYTE = 8'd254;
  localparam logic [7:0] SEP_CODE = 8'd1;

  typedef enum logic [11:0] {
    ST_START    = 12'b000000000001,
    ST_LEAD_ESC = 12'b000000000010,
    ST_LEAD_ONE = 12'b000000000100,
    ST_DATA     = 12'b000000001000,
    ST_DATA_Z   = 12'b000000010000,
    ST_CRC_HI   = 12'b000000100000,
    ST_CRC_HI_Z = 12'b000001000000,
    ST_CRC_LO   = 12'b000010000000,
    ST_CRC_LO_Z = 12'b000100000000,
    ST_SEP_ESC  = 12'b001000000000,
    ST_SEP_ONE  = 12'b010000000000,
    ST_OVF      = 12'b100000000000
  } state_t;

  state_t     state;
  state_t     cur;
  state_t     nxt;
  state_t     after_data;
  logic       beat_go;
  logic       final_beat;
  logic [7:0] beat_byte;

  // Pick the beat to emit now and the one after it
  always_comb begin
    priority if (state != ST_START) cur = state;
    else if (head.ovf)              cur = ST_OVF;
    else if (head.lead)             cur = ST_LEAD_ESC;
    else                            cur = ST_DATA;

    if (!head.last)       after_data = ST_START;
    else if (head.crc_en) after_data = ST_CRC_HI;
    else                  after_data = ST_SEP_ESC;

    nxt        = ST_START;
    final_beat = 1'b0;
    beat_byte  = 8'h00;
    unique case (cur)
      ST_LEAD_ESC: begin
        beat_byte = ESC_BYTE;
        nxt       = ST_LEAD_ONE;
      end
      ST_LEAD_ONE: begin
        beat_byte = SEP_CODE;
        nxt       = ST_DATA;
      end
      ST_DATA: begin
        beat_byte = head.data;
        if (head.data == ESC_BYTE) begin
          nxt = ST_DATA_Z;
        end else begin
          nxt        = after_data;
          final_beat = !head.last;
        end
      end
      ST_DATA_Z: begin
        nxt        = after_data;
        final_beat = !head.last;
      end
      ST_CRC_HI: begin
        beat_byte = head.crc[15:8];
        nxt       = (head.crc[15:8] == ESC_BYTE) ? ST_CRC_HI_Z : ST_CRC_LO;
      end
      ST_CRC_HI_Z: nxt = ST_CRC_LO;
      ST_CRC_LO: begin
        beat_byte = head.crc[7:0];
        nxt       = (head.crc[7:0] == ESC_BYTE) ? ST_CRC_LO_Z : ST_SEP_ESC;
      end
      ST_CRC_LO_Z: nxt = ST_SEP_ESC;
      ST_SEP_ESC: begin
        beat_byte = ESC_BYTE;
        nxt       = ST_SEP_ONE;
      end
      ST_SEP_ONE: begin
        beat_byte  = SEP_CODE;
        final_beat = 1'b1;
      end
      ST_OVF: final_beat = 1'b1;
      default: ;
    endcase
  end

  // Emit whenever a job waits and the output register is free or draining
  assign beat_go = !q_stat.empty && (!m_tvalid || m_tready);
  assign pop     = beat_go && final_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_START;
    end else if (beat_go) begin
      state <= final_beat ? ST_START : nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (beat_go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_go) begin
      m_tdata    <= beat_byte;
      m_tlast    <= final_beat;
      m_tuser[0] <= cur == ST_SEP_ONE;
      m_tuser[1] <= cur == ST_OVF;
    end
  end

endmodule

`default_nettype wire

// File: rtl/byte_stuffed_crc_framer_top.sv
// Top level of the byte-stuffed CRC-16 message framer.
//
// Input channel s_*: one payload byte a beat, s_tlast marks the last byte of a
// message. Output channel m_*: one line byte a beat; 254 is sent as 254,0,
// messages are closed by an optional stuffed CRC-16 (high byte first) and a
// 254,1 separator, and the first payload byte after reset is preceded by 254,1.
// m_tlast marks the last beat caused by one input beat, m_tuser[0] the closing
// separator, m_tuser[1] the single overflow beat of a message that ran past
// max_message_length; the rest of such a message produces nothing.
// The first line beat of an input beat passes through the job queue and then
// the back end's single output register. Each input beat yields up to 10 line
// beats, one per cycle while the receiver is ready (none for the dropped rest
// of a message). A four-entry job queue lets input be taken while line beats
// are still going out. Reset (synchronous, rst high) empties the queue, clears
// count and CRC, owes the leading separator and sets max_message_length 128,
// crc_enable 1. A stalled receiver holds m_* steady; the input stalls once the
// queue fills. Configuration (cfg_we, cfg_index, cfg_data) is to be written by
// the user only while idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module byte_stuffed_crc_framer_top #(
  parameter int MAX_MESSAGE_LIMIT = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [bscf_pkg::CFG_DW-1:0] cfg_data,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,   // payload_byte
  input  wire logic                        s_tlast,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [7:0]                       m_tdata,   // line_byte
  output logic                             m_tlast,
  output logic [1:0]                       m_tuser    // [0] frame_done, [1] overflow
);

  bscf_pkg::q_stat_t q_stat;
  bscf_pkg::job_t    push_job;
  bscf_pkg::job_t    head;
  logic              push;
  logic              pop;

  bscf_front #(
    .MAX_MESSAGE_LIMIT(MAX_MESSAGE_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  bscf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .head    (head),
    .stat    (q_stat)
  );

  bscf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .q_stat  (q_stat),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

endmodule

`default_nettype wire

// File: bench/framer_line_checker.sv
// Line-side checker for the byte-stuffed CRC framer: predicts and compares every line beat.
`timescale 1ns / 1ps

module framer_line_checker #(
  parameter int MAX_LIMIT = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [bscf_pkg::CFG_DW-1:0] cfg_data,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // payload_byte
  input  logic                        s_tlast,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [7:0]                  m_tdata,   // line_byte
  input  logic                        m_tlast,
  input  logic [1:0]                  m_tuser,   // [0] frame_done, [1] overflow
  output int                          fail_count,
  output int                          beats_owed,
  output int                          frames_closed,
  output int                          overflow_beats
);

  localparam logic [7:0] ESC = 8'hFE;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       done;
    logic       ovf;
  } line_beat_t;

  // Line beats still to come, oldest first
  line_beat_t line_q[$];

  // Shadow registers and framing state
  logic [bscf_pkg::CFG_DW-1:0] len_limit;
  logic                        crc_on;
  logic                        lead_owed;
  int unsigned                 msg_count;
  logic [15:0]                 msg_crc;
  logic                        dropping;

  int mismatches = 0;
  int owed_q     = 0;
  int frames     = 0;
  int ovfs       = 0;

  assign fail_count     = mismatches;
  assign beats_owed     = owed_q;
  assign frames_closed  = frames;
  assign overflow_beats = ovfs;

  // CRC-16, poly 0x1021, MSB first
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c ^ {b, 8'h00};
    for (int k = 0; k < 8; k++)
      r = r[15] ? ((r << 1) ^ 16'h1021) : (r << 1);
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < 50)
      $display("MISMATCH at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic push_beat(input logic [7:0] data, input logic done, input logic ovf);
    line_q.push_back('{data, 1'b0, done, ovf});
  endtask

  // Send 254 as 254,0
  task automatic push_stuffed(input logic [7:0] b);
    push_beat(b, 1'b0, 1'b0);
    if (b == ESC)
      push_beat(8'h00, 1'b0, 1'b0);
  endtask

  // Work out the line beats caused by one payload byte
  task automatic frame_byte(input logic [7:0] b, input logic last);
    int unsigned lim;
    lim = (len_limit > MAX_LIMIT) ? MAX_LIMIT : len_limit;

    // Drop the rest of an abandoned message silently
    if (dropping) begin
      if (last) begin
        dropping  = 1'b0;
        msg_count = 0;
        msg_crc   = '0;
      end
      return;
    end

    // Too long: one overflow beat, leading separator stays owed
    if (msg_count >= lim) begin
      msg_count = 0;
      msg_crc   = '0;
      dropping  = !last;
      push_beat(8'h00, 1'b0, 1'b1);
      line_q[line_q.size()-1].last = 1'b1;
      return;
    end

    if (lead_owed) begin
      lead_owed = 1'b0;
      push_beat(ESC, 1'b0, 1'b0);
      push_beat(8'h01, 1'b0, 1'b0);
    end

    msg_count++;
    msg_crc = crc16_step(msg_crc, b);
    push_stuffed(b);

    // Close the message: optional CRC, then separator
    if (last) begin
      if (crc_on) begin
        push_stuffed(msg_crc[15:8]);
        push_stuffed(msg_crc[7:0]);
      end
      push_beat(ESC, 1'b0, 1'b0);
      push_beat(8'h01, 1'b1, 1'b0);
      msg_count = 0;
      msg_crc   = '0;
    end
    line_q[line_q.size()-1].last = 1'b1;
  endtask

  always @(posedge clk) begin : watch
    line_beat_t want;
    if (rst) begin
      len_limit = 13'd128;
      crc_on    = 1'b1;
      lead_owed = 1'b1;
      msg_count = 0;
      msg_crc   = '0;
      dropping  = 1'b0;
      line_q.delete();
    end else begin
      // Compare each line beat with the oldest expectation
      if (m_tvalid && m_tready) begin
        if (line_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected line beat data=%02h last=%0b user=%02b",
                                  m_tdata, m_tlast, m_tuser));
        end else begin
          want = line_q.pop_front();
          if (m_tdata !== want.data)
            flag_mismatch($sformatf("line_byte %02h, want %02h", m_tdata, want.data));
          if (m_tlast !== want.last)
            flag_mismatch($sformatf("run_last %0b, want %0b (byte %02h)",
                                    m_tlast, want.last, want.data));
          if (m_tuser[0] !== want.done)
            flag_mismatch($sformatf("frame_done %0b, want %0b (byte %02h)",
                                    m_tuser[0], want.done, want.data));
          if (m_tuser[1] !== want.ovf)
            flag_mismatch($sformatf("overflow %0b, want %0b (byte %02h)",
                                    m_tuser[1], want.ovf, want.data));
          if (want.done)
            frames++;
          if (want.ovf)
            ovfs++;
        end
      end

      // Track register writes
      if (cfg_we) begin
        if (cfg_index == bscf_pkg::REG_MAX_LEN)
          len_limit = cfg_data;
        else if (cfg_index == bscf_pkg::REG_CRC_EN)
          crc_on = cfg_data[0];
      end

      if (s_tvalid && s_tready)
        frame_byte(s_tdata, s_tlast);
    end
    owed_q <= line_q.size();
  end

endmodule

// File: bench/byte_stuffed_crc_framer_top_tb.sv
// Testbench top for the byte-stuffed CRC framer: stimulus, sink pacing and verdict.
`timescale 1ns / 1ps

module byte_stuffed_crc_framer_top_tb;

  localparam int LIMIT = 4096;

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        cfg_we    = 1'b0;
  logic                        cfg_index = 1'b0;
  logic [bscf_pkg::CFG_DW-1:0] cfg_data  = '0;
  logic                        s_tvalid  = 1'b0;
  logic [7:0]                  s_tdata   = 8'h00;
  logic                        s_tlast   = 1'b0;
  logic                        m_tready  = 1'b0;
  wire logic                   s_tready;
  wire logic                   m_tvalid;
  wire logic [7:0]             m_tdata;
  wire logic                   m_tlast;
  wire logic [1:0]             m_tuser;

  int fail_count;
  int beats_owed;
  int frames_closed;
  int overflow_beats;

  bit gaps_on      = 1'b0;
  bit hold_off_req = 1'b0;
  int bytes_sent   = 0;
  int settings_run = 0;

  always #10 clk = ~clk;

  byte_stuffed_crc_framer_top #(.MAX_MESSAGE_LIMIT(LIMIT)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  framer_line_checker #(.MAX_LIMIT(LIMIT)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .fail_count(fail_count), .beats_owed(beats_owed),
    .frames_closed(frames_closed), .overflow_beats(overflow_beats)
  );

  // Line sink: random stall bursts, plus one long hold-off on request
  initial begin : line_sink
    int stall_left;
    bit held;
    stall_left = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (hold_off_req && !held) begin
        held       = 1'b1;
        stall_left = 299;
        m_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 11);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Offer one payload beat and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  // Random content, biased towards the escape value
  task automatic send_random_message(input int len);
    for (int i = 0; i < len; i++)
      send_byte(($urandom_range(0, 4) == 0) ? 8'hFE : 8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // Drain: wait for every expected line beat, then let trailing work finish
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (beats_owed != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [bscf_pkg::CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One setting, then random messages: mostly within the limit, some past it when the limit is 16 or less
  task automatic random_phase(input logic [bscf_pkg::CFG_DW-1:0] len, input logic crc,
                              input int items);
    int eff;
    int cap;
    int counted;
    int n;
    write_reg(bscf_pkg::REG_MAX_LEN, len);
    write_reg(bscf_pkg::REG_CRC_EN, {12'($urandom), crc});
    settings_run++;
    eff     = (len > LIMIT) ? LIMIT : len;
    cap     = (eff < 16) ? eff : 16;
    counted = 0;
    while (counted < items) begin
      if (eff <= 16 && $urandom_range(0, 3) == 0)
        n = eff + $urandom_range(1, 3);
      else
        n = $urandom_range(1, cap);
      send_random_message(n);
      counted += n;
    end
    settle();
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst     <= 1'b0;
    gaps_on <= 1'b1;

    // Overflow on the very first byte leaves the leading separator owed
    write_reg(bscf_pkg::REG_MAX_LEN, 13'd0);
    settings_run++;
    send_byte(8'h42, 1'b1);
    settle();

    // CRC left at its reset setting; extremes and escape bytes
    write_reg(bscf_pkg::REG_MAX_LEN, 13'd128);
    settings_run++;
    send_byte(8'h00, 1'b1);
    send_byte(8'hFE, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h7E, 1'b0);
    send_byte(8'h80, 1'b1);
    settle();

    // No CRC, limit 3: overflow on a last byte, then overflow mid-message
    write_reg(bscf_pkg::REG_MAX_LEN, 13'd3);
    write_reg(bscf_pkg::REG_CRC_EN, 13'd0);
    settings_run++;
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b1);
    repeat (5) send_byte(8'hFE, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hA5, 1'b1);
    settle();

    // Zero limit: every message overflows on its first byte
    write_reg(bscf_pkg::REG_MAX_LEN, 13'd0);
    write_reg(bscf_pkg::REG_CRC_EN, 13'd1);
    settings_run++;
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    send_byte(8'hFE, 1'b1);
    settle();

    // Limit of one
    write_reg(bscf_pkg::REG_MAX_LEN, 13'd1);
    settings_run++;
    send_byte(8'hFE, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b1);
    settle();

    // All-ones limit is held to the build limit: a 20-byte message goes through whole
    gaps_on <= 1'b0;
    write_reg(bscf_pkg::REG_MAX_LEN, {bscf_pkg::CFG_DW{1'b1}});
    settings_run++;
    send_random_message(20);
    settle();
    gaps_on <= 1'b1;

    // Random phases; the second one rides out a long sink hold-off
    random_phase(13'($urandom_range(1, 6)), 1'b0, 40);
    hold_off_req <= 1'b1;
    random_phase(13'($urandom_range(2, 12)), 1'b1, 40);
    random_phase(13'd4096, 1'b1, 40);
    random_phase(13'd1, 1'($urandom_range(0, 1)), 40);
    gaps_on <= 1'b0;
    random_phase(13'($urandom_range(2, 24)), 1'b1, 40);

    $display("Run covered %0d payload beats over %0d register settings, limits 0 to saturated.",
             bytes_sent, settings_run);
    $display("Checked %0d closed frames and %0d overflow beats, with stalls on both sides.",
             frames_closed, overflow_beats);
    if (fail_count == 0 && beats_owed == 0) begin
      $display("byte_stuffed_crc_framer_top test passed");
    end else begin
      $display("byte_stuffed_crc_framer_top test failed");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #40_000_000;
    $display("byte_stuffed_crc_framer_top test failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/bscf_pkg.sv
rtl/bscf_front.sv
rtl/bscf_queue.sv
rtl/bscf_back.sv
rtl/byte_stuffed_crc_framer_top.sv
bench/framer_line_checker.sv
bench/byte_stuffed_crc_framer_top_tb.sv
